/* rtl/icmp_er_pkg.sv */
// Shared types, constants and a helper function for the ICMP echo responder.
package icmp_er_pkg;

  // Counter width default and width of the counts shown on the result
  localparam int COUNTER_BITS_DEFAULT = 32;
  localparam int COUNT_OUT_BITS       = 32;

  // Message layout
  localparam int          POS_BITS          = 3;
  localparam int          HEADER_BYTES      = 4;
  localparam logic [7:0]  ECHO_REQUEST_TYPE = 8'd8;

  // Queue between the front and back parts
  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);

  // Input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } msg_t;

  // Result item
  typedef struct packed {
    logic [7:0]                out_byte;
    logic                      out_last;
    logic                      send_reply;
    logic [15:0]               reply_checksum;
    logic [COUNT_OUT_BITS-1:0] received_count;
    logic [COUNT_OUT_BITS-1:0] answered_count;
  } res_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic [7:0] ob;     // rewritten byte
    logic       last;   // final byte of the message
    logic       reply;  // final byte of an echo request
  } cls_t;

  // Queue status seen by the front part
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // 16-bit ones-complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

/* rtl/icmp_echo_responder.sv */
// Top level of the ICMP echo responder: front part, queue and back part.
//
// Takes an ICMP message one byte per item and returns one rewritten byte per
// item, with header bytes 0 to 3 zeroed. On the final byte the result carries
// the verdict (1 = answer as echo reply, type 8 received) and the complemented
// ones-complement checksum of the rewritten message, high byte for offset 2.
// Received and answered counts wrap at COUNTER_BITS bits; the low 32 bits are
// shown. Sustained rate is one byte per cycle while the result side does not
// stall; the back part folds words in with a 16-bit ones-complement add. An
// accepted byte is registered in the queue and then in the result register; a
// four-item queue between the classifying front part and the back part absorbs output stalls.
module icmp_echo_responder #(
  parameter int COUNTER_BITS = icmp_er_pkg::COUNTER_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               msg_valid,
  output logic               msg_stall,
  input  icmp_er_pkg::msg_t  msg,
  output logic               res_valid,
  input  logic               res_stall,
  output icmp_er_pkg::res_t  res
);

  icmp_er_pkg::q_status_t q_status;
  icmp_er_pkg::cls_t      q_item;
  icmp_er_pkg::cls_t      q_head;
  logic                   q_push;
  logic                   q_pop;

  icmp_er_front u_front (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg       (msg),
    .q_status  (q_status),
    .q_push    (q_push),
    .q_item    (q_item)
  );

  icmp_er_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .status    (q_status),
    .pop       (q_pop),
    .head      (q_head)
  );

  icmp_er_back #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

/* rtl/icmp_er_front.sv */
// Front part: accepts bytes, tracks header offset and classifies each item.
module icmp_er_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    msg_valid,
  output logic                    msg_stall,
  input  icmp_er_pkg::msg_t       msg,
  input  icmp_er_pkg::q_status_t  q_status,
  output logic                    q_push,
  output icmp_er_pkg::cls_t       q_item
);

  logic [icmp_er_pkg::POS_BITS-1:0] byte_position;
  logic [icmp_er_pkg::POS_BITS-1:0] byte_position_next;
  logic                             request_seen;
  logic                             request_seen_next;
  logic                             in_header;
  logic                             is_first;

  // Accept whenever the queue has room
  assign msg_stall = q_status.full;
  assign q_push    = msg_valid && !q_status.full;

  // Classification of the current byte
  assign is_first  = (byte_position == '0);
  assign in_header = (byte_position < icmp_er_pkg::POS_BITS'(icmp_er_pkg::HEADER_BYTES));

  always_comb begin
    request_seen_next = is_first ? (msg.data_byte == icmp_er_pkg::ECHO_REQUEST_TYPE)
                                 : request_seen;
    if (msg.last_byte) begin
      byte_position_next = '0;
    end else if (in_header) begin
      byte_position_next = byte_position + 1'b1;
    end else begin
      byte_position_next = byte_position;
    end
    q_item.ob    = in_header ? 8'h00 : msg.data_byte;
    q_item.last  = msg.last_byte;
    q_item.reply = msg.last_byte && request_seen_next;
  end

  // Per-message offset and verdict
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      request_seen  <= 1'b0;
    end else if (q_push) begin
      byte_position <= byte_position_next;
      request_seen  <= request_seen_next;
    end
  end

endmodule

/* rtl/icmp_er_fifo.sv */
// Short register queue of classified items between the front and back parts.
module icmp_er_fifo (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  icmp_er_pkg::cls_t       push_item,
  output icmp_er_pkg::q_status_t  status,
  input  logic                    pop,
  output icmp_er_pkg::cls_t       head
);

  icmp_er_pkg::cls_t                      entries [icmp_er_pkg::QUEUE_DEPTH];
  logic [icmp_er_pkg::QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [icmp_er_pkg::QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [icmp_er_pkg::QUEUE_PTR_BITS:0]   count;

  assign status.full  = (count == (icmp_er_pkg::QUEUE_PTR_BITS+1)'(icmp_er_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign head         = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Fill count stays within the depth; no push when full, no pop when empty
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (icmp_er_pkg::QUEUE_PTR_BITS+1)'(icmp_er_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && status.full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && status.empty))
    else $error("pop from empty queue");

endmodule

/* rtl/icmp_er_back.sv */
// Back part: checksum accumulation, message counters and the result register.
module icmp_er_back #(
  parameter int COUNTER_BITS = icmp_er_pkg::COUNTER_BITS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  icmp_er_pkg::q_status_t  q_status,
  input  icmp_er_pkg::cls_t       q_head,
  output logic                    q_pop,
  output logic                    res_valid,
  input  logic                    res_stall,
  output icmp_er_pkg::res_t       res
);

  logic                    odd_offset;
  logic [7:0]              pending_high_byte;
  logic [15:0]             running_sum;
  logic [COUNTER_BITS-1:0] received_total;
  logic [COUNTER_BITS-1:0] answered_total;
  logic [COUNTER_BITS-1:0] received_next;
  logic [COUNTER_BITS-1:0] answered_next;
  logic [15:0]             word_in;
  logic [15:0]             sum_add;
  logic [icmp_er_pkg::COUNT_OUT_BITS-1:0] received_shown;
  logic [icmp_er_pkg::COUNT_OUT_BITS-1:0] answered_shown;
  icmp_er_pkg::res_t       res_next;

  // Take the next item when the result register is free or being emptied
  assign q_pop = !q_status.empty && (!res_valid || !res_stall);

  // A final byte at even offset is padded with a zero low byte
  assign word_in = odd_offset ? {pending_high_byte, q_head.ob} : {q_head.ob, 8'h00};
  assign sum_add = icmp_er_pkg::oc_add(running_sum, word_in);

  assign received_next = received_total + COUNTER_BITS'(q_head.last);
  assign answered_next = answered_total + COUNTER_BITS'(q_head.reply);

  // Counts shown at a fixed width
  if (COUNTER_BITS >= icmp_er_pkg::COUNT_OUT_BITS) begin : g_cnt_trunc
    assign received_shown = received_next[icmp_er_pkg::COUNT_OUT_BITS-1:0];
    assign answered_shown = answered_next[icmp_er_pkg::COUNT_OUT_BITS-1:0];
  end else begin : g_cnt_ext
    assign received_shown = {{(icmp_er_pkg::COUNT_OUT_BITS-COUNTER_BITS){1'b0}}, received_next};
    assign answered_shown = {{(icmp_er_pkg::COUNT_OUT_BITS-COUNTER_BITS){1'b0}}, answered_next};
  end

  // Result item for the popped byte
  always_comb begin
    res_next.out_byte       = q_head.ob;
    res_next.out_last       = q_head.last;
    res_next.send_reply     = q_head.reply;
    res_next.reply_checksum = q_head.last ? ~sum_add : 16'h0000;
    res_next.received_count = received_shown;
    res_next.answered_count = answered_shown;
  end

  // Checksum and counter state
  always_ff @(posedge clk) begin
    if (rst) begin
      odd_offset        <= 1'b0;
      pending_high_byte <= 8'h00;
      running_sum       <= 16'h0000;
      received_total    <= '0;
      answered_total    <= '0;
    end else if (q_pop) begin
      received_total <= received_next;
      answered_total <= answered_next;
      if (q_head.last) begin
        odd_offset        <= 1'b0;
        pending_high_byte <= 8'h00;
        running_sum       <= 16'h0000;
      end else if (odd_offset) begin
        odd_offset        <= 1'b0;
        pending_high_byte <= 8'h00;
        running_sum       <= sum_add;
      end else begin
        odd_offset        <= 1'b1;
        pending_high_byte <= q_head.ob;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (q_pop) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res <= res_next;
    end
  end

  // Verdict and checksum only on the final byte
  a_verdict_on_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.out_last |-> !res.send_reply && (res.reply_checksum == 16'h0000))
    else $error("verdict outside final byte");
  // Word phase alternates on every non-final byte
  a_phase_toggle: assert property (@(posedge clk) disable iff (rst)
    q_pop && !q_head.last |=> odd_offset == !$past(odd_offset))
    else $error("word phase did not toggle");
  // State returns to offset zero after a final byte
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    q_pop && q_head.last |=> !odd_offset && (running_sum == 16'h0000))
    else $error("message state not cleared");

endmodule

/* bench/tb_icmp_echo_responder.sv */
// Testbench for the ICMP echo responder: directed table, random messages, predictor check.
`timescale 1ns / 100ps

module tb_icmp_echo_responder;

  localparam int RANDOM_ITEMS = 1200;
  localparam int QUIET_FROM   = 1050;

  // One row of the directed table; want holds a typed-in result when typed is set
  typedef struct {
    logic [7:0]        data;
    logic              last;
    bit                typed;
    icmp_er_pkg::res_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  logic msg_valid;
  logic msg_stall;
  icmp_er_pkg::msg_t msg;
  logic res_valid;
  logic res_stall = 1'b0;
  icmp_er_pkg::res_t res;

  // Predictor state
  logic [2:0]  p_pos;
  logic        p_odd;
  logic [7:0]  p_high;
  logic [15:0] p_sum;
  logic        p_req;
  logic [31:0] p_rcvd;
  logic [31:0] p_ans;

  icmp_er_pkg::res_t rewritten_q[$];
  icmp_er_pkg::res_t want;
  int   fail_count = 0;
  int   send_pct = 0;
  int   take_pct = 0;
  int   stall_left = 0;

  // Directed items: one-byte messages, header zeroing, short and odd-length messages
  row_t dir_rows [0:24] = '{
    '{8'h08, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 16'hffff, 32'd1, 32'd1}},
    '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b0, 16'hffff, 32'd2, 32'd1}},
    '{8'h08, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 16'h0000, 32'd2, 32'd1}},
    '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 16'h0000, 32'd2, 32'd1}},
    '{8'hff, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 16'h0000, 32'd2, 32'd1}},
    '{8'hff, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 16'h0000, 32'd2, 32'd1}},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b0, '0},
    '{8'h08, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'h02, 1'b1, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h12, 1'b0, 1'b0, '0},
    '{8'h34, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'hff, 1'b1, 1'b0, '0},
    '{8'h08, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'h80, 1'b1, 1'b0, '0}
  };

  icmp_echo_responder u_top (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg       (msg),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Works out the rewritten byte, verdict, checksum and counts for one item
  task automatic predict_reply(input icmp_er_pkg::msg_t m, output icmp_er_pkg::res_t r);
    logic [7:0]  ob;
    logic [16:0] acc;
    logic [15:0] s;
    r = '0;
    if (p_pos == 3'd0) p_req = (m.data_byte == icmp_er_pkg::ECHO_REQUEST_TYPE);
    ob = (p_pos < 3'(icmp_er_pkg::HEADER_BYTES)) ? 8'h00 : m.data_byte;
    if (p_pos < 3'(icmp_er_pkg::HEADER_BYTES)) p_pos = p_pos + 3'd1;
    // high byte on even offsets, fold the word in on odd ones
    if (!p_odd) begin
      p_high = ob;
      p_odd  = 1'b1;
    end else begin
      acc    = {1'b0, p_sum} + {1'b0, p_high, ob};
      p_sum  = acc[15:0] + {15'd0, acc[16]};
      p_high = 8'h00;
      p_odd  = 1'b0;
    end
    if (m.last_byte) begin
      s = p_sum;
      // odd final byte is padded with a zero low byte
      if (p_odd) begin
        acc = {1'b0, s} + {1'b0, p_high, 8'h00};
        s   = acc[15:0] + {15'd0, acc[16]};
      end
      r.reply_checksum = ~s;
      p_rcvd = p_rcvd + 32'd1;
      if (p_req) begin
        p_ans        = p_ans + 32'd1;
        r.send_reply = 1'b1;
      end
    end
    r.out_byte       = ob;
    r.out_last       = m.last_byte;
    r.received_count = p_rcvd;
    r.answered_count = p_ans;
    // new message starts after the final byte
    if (m.last_byte) begin
      p_pos  = 3'd0;
      p_odd  = 1'b0;
      p_high = 8'h00;
      p_sum  = 16'h0000;
      p_req  = 1'b0;
    end
  endtask

  // Offers one item, with an optional idle burst first, and predicts its result
  task automatic send_byte(input logic [7:0] d, input logic l, output icmp_er_pkg::res_t r);
    icmp_er_pkg::msg_t m;
    int   gap;
    m.data_byte = d;
    m.last_byte = l;
    if (send_pct != 0 && $urandom_range(99) < send_pct) begin
      gap = $urandom_range(15, 1);
      msg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg_valid <= 1'b1;
    msg       <= m;
    @(posedge clk);
    while (msg_stall) @(posedge clk);
    predict_reply(m, r);
  endtask

  task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      fail_count++;
    end
  endtask

  // Result side stalls in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_stall  <= 1'b1;
    end else if (take_pct != 0 && $urandom_range(99) < take_pct) begin
      stall_left <= $urandom_range(15, 1) - 1;
      res_stall  <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  // Compare each taken result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (rewritten_q.size() == 0) begin
        $error("unexpected result item: out_byte %0h out_last %0b", res.out_byte, res.out_last);
        fail_count++;
      end else begin
        want = rewritten_q.pop_front();
        check_field("out_byte", 32'(want.out_byte), 32'(res.out_byte));
        check_field("out_last", 32'(want.out_last), 32'(res.out_last));
        check_field("send_reply", 32'(want.send_reply), 32'(res.send_reply));
        check_field("reply_checksum", 32'(want.reply_checksum), 32'(res.reply_checksum));
        check_field("received_count", want.received_count, res.received_count);
        check_field("answered_count", want.answered_count, res.answered_count);
      end
    end
  end

  initial begin
    icmp_er_pkg::res_t r;
    int   sent;
    int   len;
    logic [7:0] d;
    rst       = 1'b1;
    msg_valid = 1'b0;
    msg       = '0;
    p_pos  = 3'd0;
    p_odd  = 1'b0;
    p_high = 8'h00;
    p_sum  = 16'h0000;
    p_req  = 1'b0;
    p_rcvd = 32'd0;
    p_ans  = 32'd0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed table, no idling
    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].data, dir_rows[i].last, r);
      rewritten_q.push_back(dir_rows[i].typed ? dir_rows[i].want : r);
    end

    // Random messages: mostly well-formed, some short or garbage
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= QUIET_FROM) begin
        send_pct = 0;
        take_pct = 0;
      end else if ($urandom_range(9) == 0) begin
        case ($urandom_range(2))
          0: begin send_pct = 0;  take_pct = 0;  end
          1: begin send_pct = 15; take_pct = 15; end
          default: begin send_pct = 40; take_pct = 40; end
        endcase
      end
      if ($urandom_range(99) < 85) len = $urandom_range(40, 5);
      else len = $urandom_range(4, 1);
      for (int k = 0; k < len; k++) begin
        d = 8'($urandom_range(255));
        if (k == 0 && $urandom_range(1) == 0) d = icmp_er_pkg::ECHO_REQUEST_TYPE;
        send_byte(d, (k == len - 1), r);
        rewritten_q.push_back(r);
        sent++;
      end
    end
    msg_valid <= 1'b0;

    // Drain and let the pipeline settle
    while (rewritten_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
